// ===== design/psg_pkg.sv =====
package psg_pkg;

   // Default sizes handed to the top level parameters
   localparam int unsigned PhaseBitsDef     = 32;
   localparam int unsigned TableAddrBitsDef = 10;
   localparam int unsigned SampleBitsDef    = 16;

   // Fixed field widths of the ports
   localparam int unsigned PhaseFieldBits  = 32;
   localparam int unsigned SampleFieldBits = 16;
   localparam int unsigned CsrIndexBits    = 1;
   localparam int unsigned CsrDataBits     = 32;
   localparam int unsigned AmpBits         = 16;

   // Register indexes of the csr port
   localparam logic [CsrIndexBits-1:0] CsrPhaseStep = 1'b0;
   localparam logic [CsrIndexBits-1:0] CsrAmplitude = 1'b1;

   // Amplitude 1.0 in Q1.15, also its reset value
   localparam logic [AmpBits-1:0] AmpOne = 16'd32768;

   // Depth of the queue between front and back
   localparam int unsigned QueueDepth = 4;

   // Fixed-point sine series constants (Q2.30)
   localparam logic [63:0] Q30One    = 64'd1 << 30;
   localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
   // Horner divisors (2k)(2k+1) for k = 1..8
   localparam logic [63:0] SineDiv [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

   typedef enum logic {
      ACT_GENERATE = 1'b0,
      ACT_LOAD     = 1'b1
   } action_type;

   typedef struct packed {
      action_type                action;
      logic [PhaseFieldBits-1:0] phase_value;
      logic                      end_of_buffer;
   } req_type;

   typedef struct packed {
      logic signed [SampleFieldBits-1:0] sample;
      logic [PhaseFieldBits-1:0]         current_phase;
      logic                              last;
   } rsp_type;

   // One classified beat on its way from front to back
   typedef struct packed {
      logic                      gen;
      logic                      neg;
      logic                      full_scale;
      logic                      last;
      logic [PhaseFieldBits-1:0] current_phase;
   } job_type;

   // sin(x) for x in Q2.30, truncating every product to Q30
   function automatic logic [63:0] sine_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] prod;
      logic [63:0] term;
      x2 = (x * x) >> 30;
      t  = Q30One;
      for (int k = 8; k >= 1; k--) begin
         prod = (x2 * t) >> 30;
         term = prod / SineDiv[k];
         t    = (term >= Q30One) ? 64'd0 : Q30One - term;
      end
      return (x * t) >> 30;
   endfunction

   // Quarter-wave entry i, rounded to nearest and clipped to full scale
   function automatic logic [63:0] sine_entry(input logic [63:0] i,
                                               input int unsigned addr_bits,
                                               input int unsigned sample_bits);
      logic [63:0] x;
      logic [63:0] s;
      logic [63:0] fs;
      logic [63:0] v;
      x  = (i * HalfPiQ30) >> addr_bits;
      s  = sine_q30(x);
      fs = (64'd1 << (sample_bits - 1)) - 64'd1;
      v  = (s * fs + (Q30One >> 1)) >> 30;
      if (v > fs) begin
         v = fs;
      end
      return v;
   endfunction

endpackage

// ===== design/psg_front.sv =====
module psg_front #(
   parameter int unsigned PHASE_BITS      = psg_pkg::PhaseBitsDef,
   parameter int unsigned TABLE_ADDR_BITS = psg_pkg::TableAddrBitsDef
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  psg_pkg::req_type                  req_data,
   input  logic [psg_pkg::PhaseFieldBits-1:0] phase_step,
   input  logic                              queue_ready,
   output logic                              push,
   output psg_pkg::job_type                  push_job,
   output logic [TABLE_ADDR_BITS-1:0]        push_addr
);

   localparam int unsigned TopBits = TABLE_ADDR_BITS + 2;

   logic [PHASE_BITS-1:0]      acc_ff;
   logic [PHASE_BITS-1:0]      acc_in;
   logic [63:0]                step_wide;
   logic [63:0]                load_wide;
   logic [63:0]                acc_wide;
   logic [TopBits-1:0]         top;
   logic [1:0]                 quadrant;
   logic [TABLE_ADDR_BITS-1:0] idx;
   logic                       accept;

   // Beat taken whenever the queue has room
   assign req_ready = queue_ready;
   assign accept    = req_valid && req_ready;
   assign push      = accept;

   // Next phase: load replaces, generate advances by the tuning word
   assign step_wide = 64'(phase_step);
   assign load_wide = 64'(req_data.phase_value);
   always_comb begin
      if (req_data.action == psg_pkg::ACT_LOAD) begin
         acc_in = load_wide[PHASE_BITS-1:0];
      end else begin
         acc_in = acc_ff + step_wide[PHASE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (accept) begin
         acc_ff <= acc_in;
      end
   end

   // Quarter-wave lookup decode from the phase before the update
   assign top      = acc_ff[PHASE_BITS-1 -: TopBits];
   assign quadrant = top[TopBits-1 -: 2];
   assign idx      = top[TABLE_ADDR_BITS-1:0];
   assign acc_wide = 64'(acc_in);

   always_comb begin
      push_addr                = quadrant[0] ? (TABLE_ADDR_BITS'(0) - idx) : idx;
      push_job.gen             = (req_data.action == psg_pkg::ACT_GENERATE);
      push_job.neg             = quadrant[1];
      push_job.full_scale      = quadrant[0] && (idx == '0);
      push_job.last            = req_data.end_of_buffer;
      push_job.current_phase   = acc_wide[psg_pkg::PhaseFieldBits-1:0];
   end

   // The mirrored address of the peak wraps to entry zero
   a_full_scale_addr: assert property (@(posedge clock) disable iff (reset)
      push && push_job.full_scale |-> push_addr == '0)
      else $error("full-scale beat with nonzero table address");

endmodule

// ===== design/psg_queue.sv =====
module psg_queue #(
   parameter int unsigned ADDR_BITS = psg_pkg::TableAddrBitsDef
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  psg_pkg::job_type       push_job,
   input  logic [ADDR_BITS-1:0]   push_addr,
   output logic                   push_ready,
   input  logic                   pop,
   output logic                   pop_valid,
   output psg_pkg::job_type       pop_job,
   output logic [ADDR_BITS-1:0]   pop_addr
);

   localparam int unsigned PtrBits = $clog2(psg_pkg::QueueDepth);
   localparam int unsigned CntBits = $clog2(psg_pkg::QueueDepth + 1);

   psg_pkg::job_type     job_mem_ff  [psg_pkg::QueueDepth];
   logic [ADDR_BITS-1:0] addr_mem_ff [psg_pkg::QueueDepth];
   logic [PtrBits-1:0]   wr_ptr_ff;
   logic [PtrBits-1:0]   rd_ptr_ff;
   logic [CntBits-1:0]   count_ff;
   logic [CntBits-1:0]   count_in;

   assign push_ready = (count_ff != CntBits'(psg_pkg::QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = job_mem_ff[rd_ptr_ff];
   assign pop_addr   = addr_mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntBits'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntBits'(1);
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PtrBits'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrBits'(1);
         end
         count_ff <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         job_mem_ff[wr_ptr_ff]  <= push_job;
         addr_mem_ff[wr_ptr_ff] <= push_addr;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !push_ready |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !pop_valid |-> !pop)
      else $error("pop from empty queue");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CntBits'(1))
      else $error("fill count did not follow a lone push");

endmodule

// ===== design/psg_back.sv =====
module psg_back #(
   parameter int unsigned TABLE_ADDR_BITS = psg_pkg::TableAddrBitsDef,
   parameter int unsigned SAMPLE_BITS     = psg_pkg::SampleBitsDef
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   input  psg_pkg::job_type             job,
   input  logic [TABLE_ADDR_BITS-1:0]   job_addr,
   output logic                         job_pop,
   input  logic [psg_pkg::AmpBits-1:0]  amplitude,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output psg_pkg::rsp_type             rsp_data
);

   localparam int unsigned MagBits   = SAMPLE_BITS - 1;
   localparam int unsigned TableSize = 1 << TABLE_ADDR_BITS;
   localparam int unsigned ProdBits  = MagBits + psg_pkg::AmpBits;
   localparam int unsigned WideBits  = (SAMPLE_BITS > psg_pkg::SampleFieldBits) ?
                                       SAMPLE_BITS : psg_pkg::SampleFieldBits;
   localparam logic [MagBits-1:0]  FullScale = {MagBits{1'b1}};
   localparam logic [ProdBits-1:0] RoundHalf = ProdBits'(1) << 14;

   typedef logic [MagBits-1:0] rom_type [TableSize];

   function automatic rom_type build_rom();
      rom_type r;
      for (int i = 0; i < TableSize; i++) begin
         r[i] = MagBits'(psg_pkg::sine_entry(64'(i), TABLE_ADDR_BITS, SAMPLE_BITS));
      end
      return r;
   endfunction

   localparam rom_type SineRom = build_rom();

   logic                        adv;
   logic                        s1_valid_ff;
   psg_pkg::job_type            s1_job_ff;
   logic [MagBits-1:0]          rom_ff;
   logic                        s2_valid_ff;
   psg_pkg::job_type            s2_job_ff;
   logic [MagBits-1:0]          s2_mag_ff;
   logic                        rsp_valid_ff;
   psg_pkg::rsp_type            rsp_data_ff;
   logic [psg_pkg::AmpBits-1:0] amp_sat;
   logic [MagBits-1:0]          mag_sel;
   logic [ProdBits-1:0]         prod;
   logic [WideBits-1:0]         mag_ext;
   logic [WideBits-1:0]         signed_val;
   psg_pkg::rsp_type            rsp_data_in;

   // Whole pipe moves when the output register is free or being drained
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign job_pop   = adv && job_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Stage 1: table read
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_job_ff <= job;
         rom_ff    <= SineRom[job_addr];
      end
   end

   // Stage 2: gain with round half up
   assign amp_sat = (amplitude > psg_pkg::AmpOne) ? psg_pkg::AmpOne : amplitude;
   assign mag_sel = s1_job_ff.full_scale ? FullScale : rom_ff;
   assign prod    = ProdBits'(mag_sel) * ProdBits'(amp_sat) + RoundHalf;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_job_ff <= s1_job_ff;
         s2_mag_ff <= prod[MagBits+14:15];
      end
   end

   // Stage 3: sign, field width, zero for load beats
   always_comb begin
      mag_ext                   = WideBits'(s2_mag_ff);
      signed_val                = s2_job_ff.neg ? (WideBits'(0) - mag_ext) : mag_ext;
      rsp_data_in.sample        = s2_job_ff.gen ?
                                  $signed(signed_val[psg_pkg::SampleFieldBits-1:0]) : '0;
      rsp_data_in.current_phase = s2_job_ff.current_phase;
      rsp_data_in.last          = s2_job_ff.last;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= job_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // A held result keeps the beats behind it in place
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> s2_valid_ff == $past(s2_valid_ff) && s1_valid_ff == $past(s1_valid_ff))
      else $error("pipe moved while output stalled");

endmodule

// ===== design/phase_continuous_sine_generator.sv =====
// Phase-continuous sine generator (DDS oscillator).
// Request channel (req_valid/req_ready/req_data): each beat is either a
// generate, which emits amplitude * sin(phase) and then advances the phase
// by the tuning word, or a load, which sets the phase and emits sample 0.
// Response channel (rsp_valid/rsp_ready/rsp_data): exactly one beat per
// request, in order, carrying the sample, the phase after the request and
// a copy of end_of_buffer.
// CSR port: csr_we writes csr_wdata to register csr_index (0 = tuning word,
// 1 = amplitude in Q1.15, clipped at 1.0); write only while idle.
// One beat per cycle is sustained while the receiver keeps rsp_ready
// high, set by the single phase adder in the front and the one
// table read and one multiply per stage in the back.
// A 4-entry queue sits between front and back: when the receiver stalls
// the back holds, the queue fills, and req_ready drops once it is full.
// Reset (synchronous) clears the phase to zero, the tuning word to zero,
// the amplitude to 1.0 and empties the queue and the pipe.
module phase_continuous_sine_generator #(
   parameter int unsigned PHASE_BITS      = psg_pkg::PhaseBitsDef,
   parameter int unsigned TABLE_ADDR_BITS = psg_pkg::TableAddrBitsDef,
   parameter int unsigned SAMPLE_BITS     = psg_pkg::SampleBitsDef
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  psg_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output psg_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [psg_pkg::CsrIndexBits-1:0]    csr_index,
   input  logic [psg_pkg::CsrDataBits-1:0]     csr_wdata
);

   logic [psg_pkg::PhaseFieldBits-1:0] phase_step_ff;
   logic [psg_pkg::AmpBits-1:0]        amplitude_ff;
   logic                               queue_ready;
   logic                               push;
   psg_pkg::job_type                   push_job;
   logic [TABLE_ADDR_BITS-1:0]         push_addr;
   logic                               pop;
   logic                               pop_valid;
   psg_pkg::job_type                   pop_job;
   logic [TABLE_ADDR_BITS-1:0]         pop_addr;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= '0;
         amplitude_ff  <= psg_pkg::AmpOne;
      end else if (csr_we) begin
         case (csr_index)
            psg_pkg::CsrPhaseStep: phase_step_ff <= csr_wdata[psg_pkg::PhaseFieldBits-1:0];
            psg_pkg::CsrAmplitude: amplitude_ff  <= csr_wdata[psg_pkg::AmpBits-1:0];
            default: ;
         endcase
      end
   end

   psg_front #(
      .PHASE_BITS      (PHASE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .phase_step  (phase_step_ff),
      .queue_ready (queue_ready),
      .push        (push),
      .push_job    (push_job),
      .push_addr   (push_addr)
   );

   psg_queue #(
      .ADDR_BITS (TABLE_ADDR_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .push_addr  (push_addr),
      .push_ready (queue_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_addr   (pop_addr)
   );

   psg_back #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job       (pop_job),
      .job_addr  (pop_addr),
      .job_pop   (pop),
      .amplitude (amplitude_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
